### rtl/core/itrb_pkg.sv
// ----------------------------------------------------------------------------
// itrb_pkg
// Shared types and constants of the IDCT reorder/transpose buffer: command
// codes, store geometry, butterfly column order and the control-to-store bus.
// ----------------------------------------------------------------------------
package itrb_pkg;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  localparam int BLOCK_SIZE = 64;
  localparam int ADDR_W     = 7;
  localparam int DEPTH      = 128;
  localparam int CNT_W      = 7;

  // Column that each slot of a row lands in (butterfly order)
  localparam logic [2:0] COL_ORDER [8] = '{
    3'd0, 3'd7, 3'd3, 3'd4, 3'd1, 3'd6, 3'd2, 3'd5
  };

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_last;
  } ram_req_t;

endpackage

### rtl/core/itrb_ram.sv
// ----------------------------------------------------------------------------
// itrb_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data, updated only under read enable.
// ----------------------------------------------------------------------------
module itrb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/itrb_ctrl.sv
// ----------------------------------------------------------------------------
// itrb_ctrl
// Bank control: write counter with butterfly column order, column-major
// read sequencer and bank swap once the write bank is full and drained.
// ----------------------------------------------------------------------------
module itrb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  itrb_pkg::cmd_e     command_i,
  output itrb_pkg::ram_req_t req_o
);

  logic [itrb_pkg::CNT_W-1:0] write_count_q, write_count_d;
  logic [itrb_pkg::CNT_W-1:0] read_rem_q, read_rem_d;
  logic                       write_bank_q, write_bank_d;

  logic                       wr_go, rd_go;
  logic [itrb_pkg::CNT_W-1:0] wc_step, rr_step, pos_full;
  logic [5:0]                 pos;

  // write_count never exceeds 64, so bit 6 alone marks a full bank
  assign wr_go = accept_i && (command_i == itrb_pkg::CMD_WRITE) && !write_count_q[6];
  assign rd_go = accept_i && (read_rem_q != '0);

  assign pos_full = itrb_pkg::CNT_W'(itrb_pkg::BLOCK_SIZE) - read_rem_q;
  assign pos      = pos_full[5:0];

  always_comb begin
    req_o.wr_en   = wr_go;
    req_o.wr_addr = {write_bank_q, write_count_q[5:3],
                     itrb_pkg::COL_ORDER[write_count_q[2:0]]};
    req_o.rd_en   = rd_go;
    // column-major: position gives column in high bits, row in low bits
    req_o.rd_addr = {~write_bank_q, pos[2:0], pos[5:3]};
    req_o.rd_last = (read_rem_q == itrb_pkg::CNT_W'(1));
  end

  assign wc_step = wr_go ? write_count_q + itrb_pkg::CNT_W'(1) : write_count_q;
  assign rr_step = rd_go ? read_rem_q - itrb_pkg::CNT_W'(1) : read_rem_q;

  always_comb begin
    write_count_d = wc_step;
    read_rem_d    = rr_step;
    write_bank_d  = write_bank_q;
    // swap once the full bank may take over the drained one
    if (accept_i && (rr_step == '0) &&
        (wc_step == itrb_pkg::CNT_W'(itrb_pkg::BLOCK_SIZE))) begin
      write_bank_d  = ~write_bank_q;
      read_rem_d    = itrb_pkg::CNT_W'(itrb_pkg::BLOCK_SIZE);
      write_count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_count_q <= '0;
      read_rem_q    <= '0;
      write_bank_q  <= 1'b0;
    end else begin
      write_count_q <= write_count_d;
      read_rem_q    <= read_rem_d;
      write_bank_q  <= write_bank_d;
    end
  end

endmodule

### rtl/core/idct_reorder_transpose_buffer_top.sv
// ----------------------------------------------------------------------------
// idct_reorder_transpose_buffer_top
// Ping-pong 8x8 reorder and transpose stage between the row and column
// transforms of a 2D IDCT.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o): one command per transfer. A write
// command stores sample_i into the write bank (row by row, butterfly column
// order) and also pops one pending output; a flush only pops. Samples that
// arrive while the write bank is full and still waiting for the read bank
// to drain are dropped.
// Output channel (out_valid_o/out_ready_i): the read bank, column-major,
// one value per transfer; block_last_o marks the 64th value of a block.
// Path: each result passes the store read register, then the output
// register. Throughput: one transfer per cycle on both sides when the
// receiver does not stall; the one-port-each bank store sets that figure.
// When the receiver stalls, the output register and the store read stage
// fill and then in_ready_o drops; no result is lost.
// Reset clears the counters and the pipeline valids. The store contents
// are not cleared: a bank is read only after all 64 of its entries were
// written.
// ----------------------------------------------------------------------------
module idct_reorder_transpose_buffer_top #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic signed [15:0] sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] value_o,
  output logic               block_last_o
);

  itrb_pkg::ram_req_t            req;
  logic                          accept;
  logic signed [SAMPLE_WIDTH-1:0] wr_data;
  logic signed [SAMPLE_WIDTH-1:0] rd_data;

  logic        s1_valid_q, s1_valid_d;
  logic        s1_last_q;
  logic        s1_move;
  logic        out_valid_q, out_valid_d;
  logic [15:0] value_q;
  logic        last_q;

  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign accept     = in_valid_i && in_ready_o;

  itrb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .command_i (itrb_pkg::cmd_e'(command_i)),
    .req_o     (req)
  );

  // sign-extend or truncate into the store width
  assign wr_data = SAMPLE_WIDTH'(sample_i);

  itrb_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (itrb_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req.wr_en),
    .waddr_i (req.wr_addr),
    .wdata_i (wr_data),
    .re_i    (req.rd_en),
    .raddr_i (req.rd_addr),
    .rdata_o (rd_data)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = req.rd_en;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && req.rd_en) begin
      s1_last_q <= req.rd_last;
    end
    if (s1_move) begin
      value_q <= 16'(rd_data);
      last_q  <= s1_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign block_last_o = last_q;

`ifndef ASSERT_OFF
  // a held read-stage result must block new transfers
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_move) |-> !in_ready_o)
    else $error("read stage overrun");

  // the write and read ports never touch the same bank
  a_bank_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.wr_en && req.rd_en) |-> (req.wr_addr[6] != req.rd_addr[6]))
    else $error("write and read hit the same bank");

  // the read stage only fills from a store read
  a_s1_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s1_valid_q) |-> $past(req.rd_en && accept))
    else $error("read stage filled without a store read");
`endif

endmodule
